// ===== hdl/gbwl_pkg.sv =====
// ----------------------------------------------------------------------------
// gbwl_pkg
// shared constants and types for the grid bracket weight locator
// ----------------------------------------------------------------------------
package gbwl_pkg;
    localparam int GRID_DEPTH    = 64;
    localparam int FRACTION_BITS = 16;
    localparam int IDX_W         = $clog2(GRID_DEPTH);
    localparam int CNT_W         = $clog2(GRID_DEPTH + 1);
    localparam int NUM_W         = 33 + FRACTION_BITS;
    localparam int QCNT_W        = $clog2(NUM_W + 1);

    localparam logic [1:0] REG_POINTS = 2'd0;
    localparam logic [1:0] REG_EXT_L  = 2'd1;
    localparam logic [1:0] REG_EXT_R  = 2'd2;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic fetch;
        logic div_start;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic scan_hit;
        logic scan_last;
        logic div_done;
    } t_status;
endpackage

// ===== hdl/gbwl_datapath.sv =====
// ----------------------------------------------------------------------------
// gbwl_datapath
// grid tables, linear scan, serial restoring divider and weight clamping
// ----------------------------------------------------------------------------
module gbwl_datapath (
    input  logic                          i_clk,
    input  gbwl_pkg::t_cmd                i_cmd,
    output gbwl_pkg::t_status             o_status,
    input  logic [gbwl_pkg::IDX_W-1:0]    i_point_index,
    input  logic signed [31:0]            i_coord_value,
    input  logic [gbwl_pkg::CNT_W-1:0]    i_count,
    input  logic                          i_extend_left,
    input  logic                          i_extend_right,
    output logic [gbwl_pkg::IDX_W-1:0]    o_left_index,
    output logic [gbwl_pkg::IDX_W-1:0]    o_right_index,
    output logic signed [31:0]            o_left_weight,
    output logic signed [31:0]            o_right_weight
);
    localparam int NW = gbwl_pkg::NUM_W;
    localparam int IW = gbwl_pkg::IDX_W;
    localparam int CW = gbwl_pkg::CNT_W;
    localparam logic signed [NW+1:0] ONE = (NW+2)'(1) <<< gbwl_pkg::FRACTION_BITS;

    logic signed [31:0] r_points [gbwl_pkg::GRID_DEPTH];
    logic signed [31:0] r_rd;
    logic signed [31:0] r_x;
    logic [CW-1:0]      r_i;
    logic signed [31:0] r_pr;
    logic [IW-1:0]      r_ridx, r_lidx;
    logic [NW-1:0]      r_rem, r_quo, r_den;
    logic               r_neg, r_zero;
    logic [gbwl_pkg::QCNT_W-1:0] r_qc;
    logic [CW-1:0]      n_r;
    logic               r_sel_l, r_sel_r;

    // table write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_points[i_point_index] <= i_coord_value;
        end
        r_rd <= r_points[r_i[IW-1:0]];
    end

    assign o_status.scan_hit  = (r_rd >= r_x);
    assign o_status.scan_last = (r_i >= i_count);
    assign o_status.div_done  = (r_qc == '0);

    always_comb begin
        n_r = r_i;
        if (n_r == '0) n_r = CW'(1);
        if (n_r >= i_count) n_r = i_count - CW'(1);
    end

    logic signed [33:0] w_num, w_den;
    logic [NW:0]        w_trial;
    logic signed [NW+1:0] w_lw, w_rw;

    assign w_trial = {r_rem[NW-2:0], r_quo[NW-1]} - {1'b0, r_den};

    always_comb begin
        w_lw = r_neg ? -$signed({2'b00, r_quo}) : $signed({2'b00, r_quo});
        if (w_lw > ONE && !i_extend_left) w_lw = ONE;
        else if (w_lw < 0 && !i_extend_right) w_lw = '0;
        if (r_zero) w_lw = '0;
        if (w_lw > 32'sh7fffffff) w_lw = (NW+2)'(32'sh7fffffff);
        if (w_lw < -(NW+2)'(33'sh80000000)) w_lw = -(NW+2)'(33'sh80000000);
        w_rw = ONE - w_lw;
        if (w_rw > 32'sh7fffffff) w_rw = (NW+2)'(32'sh7fffffff);
        if (w_rw < -(NW+2)'(33'sh80000000)) w_rw = -(NW+2)'(33'sh80000000);
    end

    // left bracket point arrives on the read port in the divider start cycle
    assign w_num = 34'(r_pr) - 34'(r_x);
    assign w_den = 34'(r_pr) - 34'(r_rd);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_x <= i_coord_value;
            r_i <= '0;
        end else if (i_cmd.scan_step) begin
            r_i <= r_i + CW'(1);
        end else if (r_sel_l) begin
            r_i <= r_i - CW'(1);
        end
        if (i_cmd.fetch) begin
            // r_i holds the chosen right index, then the left index
            r_ridx <= n_r[IW-1:0];
            r_lidx <= IW'(n_r - CW'(1));
            r_i    <= n_r;
        end
        if (i_cmd.div_start) begin
            r_neg  <= w_num[33] ^ w_den[33];
            r_zero <= (w_den == '0);
            r_quo  <= NW'(w_num[33] ? -w_num : w_num) << gbwl_pkg::FRACTION_BITS;
            r_den  <= NW'(w_den[33] ? -w_den : w_den);
            r_rem  <= '0;
            r_qc   <= gbwl_pkg::QCNT_W'(NW);
        end else if (i_cmd.div_step) begin
            if (!w_trial[NW]) r_rem <= w_trial[NW-1:0];
            else r_rem <= {r_rem[NW-2:0], r_quo[NW-1]};
            r_quo <= {r_quo[NW-2:0], ~w_trial[NW]};
            r_qc  <= r_qc - gbwl_pkg::QCNT_W'(1);
        end
        if (i_cmd.finish) begin
            if (i_count == CW'(1)) begin
                o_left_index   <= '0;
                o_right_index  <= '0;
                o_left_weight  <= 32'(ONE);
                o_right_weight <= '0;
            end else begin
                o_left_index   <= r_lidx;
                o_right_index  <= r_ridx;
                o_left_weight  <= 32'(w_lw);
                o_right_weight <= 32'(w_rw);
            end
        end
    end

    // latch the right bracket point as the read pipeline delivers it
    always_ff @(posedge i_clk) begin
        r_sel_l <= i_cmd.fetch;
        r_sel_r <= r_sel_l;
        if (r_sel_r) r_pr <= r_rd;
    end
endmodule

// ===== hdl/gbwl_ctrl.sv =====
// ----------------------------------------------------------------------------
// gbwl_ctrl
// sequencer for loads, scan, operand fetch, division and result transfer
// ----------------------------------------------------------------------------
module gbwl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_mode,
    input  logic              i_single,
    output logic              o_valid,
    input  logic              i_ready,
    output gbwl_pkg::t_cmd    o_cmd,
    input  gbwl_pkg::t_status i_status
);
    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_CMP, S_FETCH, S_WR, S_WL, S_PRE, S_DIV, S_FIN
    } t_state;
    t_state r_state;
    logic   w_acc;
    logic   w_fin;

    assign o_ready = (r_state == S_IDLE);
    assign w_acc   = i_valid && o_ready;
    // result register is free or is being emptied this cycle
    assign w_fin   = (r_state == S_FIN) && (!o_valid || i_ready);

    always_comb begin
        o_cmd = '0;
        o_cmd.load       = w_acc && !i_mode;
        o_cmd.scan_start = w_acc && i_mode;
        o_cmd.scan_step  = (r_state == S_CMP) && !i_status.scan_hit && !i_status.scan_last;
        o_cmd.fetch      = (r_state == S_FETCH);
        o_cmd.div_start  = (r_state == S_PRE);
        o_cmd.div_step   = (r_state == S_DIV) && !i_status.div_done;
        o_cmd.finish     = w_fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (w_fin) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
            case (r_state)
                S_IDLE:  if (w_acc && i_mode) r_state <= i_single ? S_FIN : S_RD;
                S_RD:    r_state <= S_CMP;
                S_CMP:   if (i_status.scan_hit || i_status.scan_last) r_state <= S_FETCH;
                         else r_state <= S_RD;
                S_FETCH: r_state <= S_WR;
                S_WR:    r_state <= S_WL;
                S_WL:    r_state <= S_PRE;
                S_PRE:   r_state <= S_DIV;
                S_DIV:   if (i_status.div_done) r_state <= S_FIN;
                S_FIN:   if (w_fin) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("accept while busy");
    a_valid_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_FIN)) else $error("stray result");
    a_div_after_pre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRE) |=> (r_state == S_DIV)) else $error("divider sequence");
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result dropped");
endmodule

// ===== hdl/grid_bracket_weight_locator_top.sv =====
// ----------------------------------------------------------------------------
// grid_bracket_weight_locator_top
// Sorted grid bracket search with fixed-point interpolation weights. A load
// is written to the table at the edge that accepts it, and loads can follow
// back to back. A query scans the table over its single read port, reading
// and comparing one point at a time, then fetches the operands (S_FETCH,
// S_WR, S_WL, S_PRE), runs the restoring divider at one quotient bit per
// cycle for 49 quotient bits and registers the result; a query with one point
// in use goes straight to the result register. The result waits in its output
// register while the next item is taken, and a finished query holds until that
// register is free. Only one item is in flight.
// ----------------------------------------------------------------------------
module grid_bracket_weight_locator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [5:0]  i_point_index,
    input  logic signed [31:0] i_coord_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_left_index,
    output logic [5:0]  o_right_index,
    output logic signed [31:0] o_left_weight,
    output logic signed [31:0] o_right_weight
);
    logic [6:0] r_points_in_use;
    logic       r_extend_left, r_extend_right;
    logic [gbwl_pkg::CNT_W-1:0] w_count;
    gbwl_pkg::t_cmd    w_cmd;
    gbwl_pkg::t_status w_status;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points_in_use <= 7'd1;
            r_extend_left   <= 1'b0;
            r_extend_right  <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                gbwl_pkg::REG_POINTS: r_points_in_use <= pwdata[6:0];
                gbwl_pkg::REG_EXT_L:  r_extend_left   <= pwdata[0];
                gbwl_pkg::REG_EXT_R:  r_extend_right  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            gbwl_pkg::REG_POINTS: prdata = {25'd0, r_points_in_use};
            gbwl_pkg::REG_EXT_L:  prdata = {31'd0, r_extend_left};
            gbwl_pkg::REG_EXT_R:  prdata = {31'd0, r_extend_right};
            default:              prdata = '0;
        endcase
    end

    always_comb begin
        if (r_points_in_use == '0) w_count = gbwl_pkg::CNT_W'(1);
        else if (r_points_in_use > 7'(gbwl_pkg::GRID_DEPTH))
            w_count = gbwl_pkg::CNT_W'(gbwl_pkg::GRID_DEPTH);
        else w_count = gbwl_pkg::CNT_W'(r_points_in_use);
    end

    gbwl_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_mode,
        .i_single(w_count == gbwl_pkg::CNT_W'(1)),
        .o_valid, .i_ready, .o_cmd(w_cmd), .i_status(w_status)
    );

    gbwl_datapath u_dp (
        .i_clk, .i_cmd(w_cmd), .o_status(w_status),
        .i_point_index, .i_coord_value, .i_count(w_count),
        .i_extend_left(r_extend_left), .i_extend_right(r_extend_right),
        .o_left_index, .o_right_index, .o_left_weight, .o_right_weight
    );
endmodule

// ===== bench/tb_grid_bracket_weight_locator_top.sv =====
// ----------------------------------------------------------------------------
// tb_grid_bracket_weight_locator_top
// Loads grid tables over the input channel, then queries coordinates around
// and between the points. Expected indices and weights are worked out by a
// local model of the bracket search and weight divide, and compared field by
// field with each result transfer. Runs over several point counts and
// extrapolation settings, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_grid_bracket_weight_locator_top;
    typedef enum logic {MODE_LOAD = 1'b0, MODE_QUERY = 1'b1} t_mode;

    typedef struct packed {
        t_mode       mode;
        logic [5:0]  slot;
        logic [31:0] coord;
    } t_item;

    typedef struct packed {
        logic [5:0]  left_idx;
        logic [5:0]  right_idx;
        logic [31:0] left_w;
        logic [31:0] right_w;
    } t_bracket;

    localparam int ONE = 1 << gbwl_pkg::FRACTION_BITS;
    localparam int IDLE_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_ready;
    logic        i_mode;
    logic [5:0]  i_point_index;
    logic signed [31:0] i_coord_value;
    logic        o_valid;
    logic        i_ready;
    logic [5:0]  o_left_index, o_right_index;
    logic signed [31:0] o_left_weight, o_right_weight;

    grid_bracket_weight_locator_top DUT (.*);

    t_item       pending_items[$];
    t_bracket    expected_brackets[$];
    longint      grid_pts[gbwl_pkg::GRID_DEPTH];
    int          pts_used;
    bit          ext_left, ext_right;
    int          mismatches;
    int          checked;
    int          idle_cycles;
    int          burst_left, gap_left;
    int          stall_phase;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic t_bracket locate_bracket(longint x);
        t_bracket b;
        int n, r;
        longint dx, num, lw, rw, q;
        bit neg;
        n = pts_used;
        if (n == 1) begin
            b.left_idx = 0;
            b.right_idx = 0;
            b.left_w = ONE;
            b.right_w = 0;
            return b;
        end
        r = n;
        for (int i = 0; i < n; i++) begin
            if (grid_pts[i] >= x) begin
                r = i;
                break;
            end
        end
        if (r == 0) r = 1;
        if (r == n) r = n - 1;
        dx = grid_pts[r] - grid_pts[r-1];
        if (dx == 0) begin
            lw = 0;
            rw = ONE;
        end else begin
            num = grid_pts[r] - x;
            neg = (num < 0) != (dx < 0);
            if (num < 0) num = -num;
            if (dx < 0) dx = -dx;
            q = (num <<< gbwl_pkg::FRACTION_BITS) / dx;
            lw = neg ? -q : q;
            if (lw > ONE && !ext_left) lw = ONE;
            else if (lw < 0 && !ext_right) lw = 0;
            lw = sat32(lw);
            rw = sat32(ONE - lw);
        end
        b.left_idx = 6'(r - 1);
        b.right_idx = 6'(r);
        b.left_w = 32'(lw);
        b.right_w = 32'(rw);
        return b;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_brackets.size() != 0 || i_valid)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            gbwl_pkg::REG_POINTS: pts_used = (val[6:0] == 0) ? 1 :
                                   (val[6:0] > gbwl_pkg::GRID_DEPTH) ?
                                   gbwl_pkg::GRID_DEPTH : int'(val[6:0]);
            gbwl_pkg::REG_EXT_L:  ext_left = val[0];
            default:              ext_right = val[0];
        endcase
    endtask

    task automatic push_load(int slot, longint v);
        t_item it;
        it.mode = MODE_LOAD;
        it.slot = 6'(slot);
        it.coord = 32'(v);
        pending_items.push_back(it);
        grid_pts[slot] = longint'($signed(32'(v)));
    endtask

    task automatic push_query(longint x);
        t_item it;
        it.mode = MODE_QUERY;
        it.slot = 6'($urandom);
        it.coord = 32'(x);
        pending_items.push_back(it);
        expected_brackets.push_back(locate_bracket(longint'($signed(32'(x)))));
    endtask

    // sorted table with random spacing, sometimes duplicates
    task automatic load_sorted_grid(int n, int spread);
        longint v;
        v = -longint'($urandom_range(spread)) * n / 2;
        for (int i = 0; i < n; i++) begin
            push_load(i, v);
            if ($urandom_range(9) != 0) v += $urandom_range(spread) + 1;
        end
    endtask

    function automatic longint pick_query();
        int n, k;
        n = pts_used;
        k = $urandom_range(n - 1);
        case ($urandom_range(5))
            0: return longint'($signed($urandom));
            1: return grid_pts[k];
            2: return grid_pts[0] - $urandom_range(1 << 20);
            3: return grid_pts[n-1] + $urandom_range(1 << 20);
            default: begin
                if (k == 0) return grid_pts[0];
                return grid_pts[k-1] + $urandom_range(32'(grid_pts[k] - grid_pts[k-1]));
            end
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!i_valid || o_ready) begin
            if (i_valid && o_ready) void'(pending_items.pop_front());
            if (pending_items.size() == 0) begin
                i_valid <= 1'b0;
            end else if (gap_left > 0) begin
                i_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else begin
                t_item it;
                it = pending_items[0];
                i_valid <= 1'b1;
                i_mode <= it.mode;
                i_point_index <= it.slot;
                i_coord_value <= it.coord;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(12);
                    gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(40);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_phase <= 0;
            idle_cycles <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            i_ready <= (stall_phase[9:8] == 2'b00) ? 1'b1 : ($urandom_range(3) != 0);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", idle_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            if (o_valid && i_ready) begin
                if (expected_brackets.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result transfer");
                end else begin
                    t_bracket e;
                    e = expected_brackets.pop_front();
                    checked++;
                    if (o_left_index !== e.left_idx || o_right_index !== e.right_idx ||
                        o_left_weight !== e.left_w || o_right_weight !== e.right_w) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d %0d %h %h got %0d %0d %h %h",
                                     e.left_idx, e.right_idx, e.left_w, e.right_w,
                                     o_left_index, o_right_index, o_left_weight,
                                     o_right_weight);
                    end
                end
            end
        end
    end

    initial begin
        int n;
        longint v;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_valid = 1'b0; i_mode = 1'b0; i_point_index = '0; i_coord_value = '0;
        i_ready = 1'b0;
        mismatches = 0;
        checked = 0;
        pts_used = 1; ext_left = 0; ext_right = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single point, extremes, zero step, out-of-range counts
        push_load(0, 0);
        push_query(-64'sd2147483648);
        push_query(64'sd2147483647);
        wait_drained();
        reg_write(gbwl_pkg::REG_POINTS, 32'd0);
        push_query(5);
        wait_drained();
        reg_write(gbwl_pkg::REG_POINTS, 32'd127);
        for (int i = 0; i < gbwl_pkg::GRID_DEPTH; i++)
            push_load(gbwl_pkg::GRID_DEPTH - 1 - i, i * 65536);
        push_load(63, 64'sd2147483647);
        push_load(0, -64'sd2147483648);
        push_query(-64'sd2147483648);
        push_query(64'sd2147483647);
        push_query(1000);
        wait_drained();
        reg_write(gbwl_pkg::REG_POINTS, 32'd3);
        reg_write(gbwl_pkg::REG_EXT_L, 32'd1);
        reg_write(gbwl_pkg::REG_EXT_R, 32'd1);
        push_load(0, 0); push_load(1, 0); push_load(2, 1);
        push_query(0);
        push_query(-64'sd2147483648);
        push_query(64'sd2147483647);
        push_load(0, -64'sd2147483648); push_load(1, 64'sd2147483647);
        push_load(2, 64'sd2147483647);
        push_query(-64'sd2147483648);
        push_query(64'sd2147483647);
        push_query(0);
        wait_drained();
        // unsorted table, negative step
        reg_write(gbwl_pkg::REG_POINTS, 32'd4);
        push_load(0, 300000); push_load(1, 100000); push_load(2, 65536); push_load(3, -1);
        push_query(200000); push_query(-500000); push_query(400000);

        // random phases across settings
        for (int ph = 0; ph < 16; ph++) begin
            wait_drained();
            case (ph % 4)
                0: n = gbwl_pkg::GRID_DEPTH;
                1: n = 2;
                default: n = $urandom_range(gbwl_pkg::GRID_DEPTH, 2);
            endcase
            reg_write(gbwl_pkg::REG_POINTS, n);
            reg_write(gbwl_pkg::REG_EXT_L, ph[0]);
            reg_write(gbwl_pkg::REG_EXT_R, ph[1]);
            load_sorted_grid(n, (ph % 3 == 0) ? 32'h7FFFFFFF / n : $urandom_range(1 << 18));
            for (int k = 0; k < 90; k++) begin
                if ($urandom_range(15) == 0) begin
                    n = $urandom_range(pts_used - 1);
                    v = grid_pts[n];
                    if (n > 0 && grid_pts[n-1] < v - 1) v = v - 1;
                    push_load(n, (ph % 5 == 4) ? longint'($signed($urandom)) : v);
                end else begin
                    push_query(pick_query());
                end
                // sender waits here until every result so far has come back
                if (ph == 7 && k == 50) wait_drained();
            end
        end
        wait_drained();
        $display("checked %0d query results over 16 random table phases", checked);
        $display("covered counts 1..64, clamping and extrapolation on both sides");
        if (mismatches == 0 && expected_brackets.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== grid_bracket_weight_locator_top.f =====
hdl/gbwl_pkg.sv
hdl/gbwl_datapath.sv
hdl/gbwl_ctrl.sv
hdl/grid_bracket_weight_locator_top.sv
bench/tb_grid_bracket_weight_locator_top.sv
